// ===== hdl/cst_pkg.sv =====
package cst_pkg;

  localparam int KEYWORD_CHARS = 8;
  localparam int OFFSET_BITS   = 32;
  localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);

  localparam logic [5:0] K_IDENT   = 6'd8;
  localparam logic [5:0] K_INT     = 6'd9;
  localparam logic [5:0] K_PLUS    = 6'd10;
  localparam logic [5:0] K_MINUS   = 6'd11;
  localparam logic [5:0] K_STAR    = 6'd12;
  localparam logic [5:0] K_DIV     = 6'd13;
  localparam logic [5:0] K_MOD     = 6'd14;
  localparam logic [5:0] K_ASSIGN  = 6'd15;
  localparam logic [5:0] K_EQ      = 6'd16;
  localparam logic [5:0] K_NE      = 6'd17;
  localparam logic [5:0] K_LT      = 6'd18;
  localparam logic [5:0] K_LE      = 6'd19;
  localparam logic [5:0] K_GT      = 6'd20;
  localparam logic [5:0] K_GE      = 6'd21;
  localparam logic [5:0] K_ANDAND  = 6'd22;
  localparam logic [5:0] K_OROR    = 6'd23;
  localparam logic [5:0] K_NOT     = 6'd24;
  localparam logic [5:0] K_LPAREN  = 6'd25;
  localparam logic [5:0] K_RPAREN  = 6'd26;
  localparam logic [5:0] K_LBRACE  = 6'd27;
  localparam logic [5:0] K_RBRACE  = 6'd28;
  localparam logic [5:0] K_SEMI    = 6'd29;
  localparam logic [5:0] K_COMMA   = 6'd30;
  localparam logic [5:0] K_UNKNOWN = 6'd31;
  localparam logic [5:0] K_EOF     = 6'd32;

  localparam logic [8:0] NONE_CHAR = 9'h100;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_SLASH  = 4'd1,
    M_LINE   = 4'd2,
    M_BLOCK  = 4'd3,
    M_BSTAR  = 4'd4,
    M_IDENT  = 4'd5,
    M_NUMBER = 4'd6,
    M_MINUS  = 4'd7,
    M_OP2    = 4'd8
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] source_byte;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_number;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic two;
    out_t tok0;
    out_t tok1;
  } bundle_t;

  function automatic logic [3:0] kw_len(input logic [2:0] i);
    case (i)
      3'd0: kw_len = 4'd3;
      3'd1: kw_len = 4'd4;
      3'd2: kw_len = 4'd2;
      3'd3: kw_len = 4'd4;
      3'd4: kw_len = 4'd5;
      3'd5: kw_len = 4'd5;
      3'd6: kw_len = 4'd8;
      default: kw_len = 4'd6;
    endcase
  endfunction

  function automatic logic [63:0] kw_text(input logic [2:0] i);
    case (i)
      3'd0: kw_text = {"int", 40'd0};
      3'd1: kw_text = {"void", 32'd0};
      3'd2: kw_text = {"if", 48'd0};
      3'd3: kw_text = {"else", 32'd0};
      3'd4: kw_text = {"while", 24'd0};
      3'd5: kw_text = {"break", 24'd0};
      3'd6: kw_text = "continue";
      default: kw_text = {"return", 16'd0};
    endcase
  endfunction

endpackage

// ===== hdl/cst_front.sv =====
module cst_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  cst_pkg::in_t   in_data,
  output logic           push,
  output cst_pkg::bundle_t push_data
);
  import cst_pkg::*;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [7:0]             win_r [KEYWORD_CHARS];
  logic                   win_we;
  logic [KW_IDX_W-1:0]    win_idx;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt;
  logic [15:0]            rlen_r, rlen_nxt;
  logic [31:0]            tcnt_r, tcnt_nxt;
  logic [8:0]             lsc_r, lsc_nxt, scb_r, scb_nxt, lnb_r, lnb_nxt;
  logic                   mis_r, mis_nxt;

  logic [7:0]  b;
  logic        restart, fl_have, fl_v, em_v;
  logic [5:0]  fl_kind, em_kind;
  logic [15:0] fl_len, em_len;
  logic [OFFSET_BITS-1:0] em_start;
  logic [5:0]  id_kind;
  out_t        t_fl, t_em;

  function automatic logic is_ws4(input logic [7:0] c);
    is_ws4 = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction
  function automatic logic is_ws6(input logic [7:0] c);
    is_ws6 = is_ws4(c) || (c == 8'h0B) || (c == 8'h0C);
  endfunction
  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= "0") && (c <= "9");
  endfunction
  function automatic logic is_alp(input logic [7:0] c);
    is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction
  function automatic logic is_op2(input logic [7:0] c);
    is_op2 = (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "&") || (c == "|");
  endfunction
  function automatic logic [5:0] op2_kind(input logic [7:0] h, input logic paired);
    case (h)
      "=": op2_kind = paired ? K_EQ : K_ASSIGN;
      "!": op2_kind = paired ? K_NE : K_NOT;
      "<": op2_kind = paired ? K_LE : K_LT;
      ">": op2_kind = paired ? K_GE : K_GT;
      "&": op2_kind = paired ? K_ANDAND : K_UNKNOWN;
      default: op2_kind = paired ? K_OROR : K_UNKNOWN;
    endcase
  endfunction
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "0": single_kind = K_INT;
      "+": single_kind = K_PLUS;
      "*": single_kind = K_STAR;
      "%": single_kind = K_MOD;
      "(": single_kind = K_LPAREN;
      ")": single_kind = K_RPAREN;
      "{": single_kind = K_LBRACE;
      "}": single_kind = K_RBRACE;
      ";": single_kind = K_SEMI;
      ",": single_kind = K_COMMA;
      default: single_kind = K_UNKNOWN;
    endcase
  endfunction
  function automatic logic sign_ok(input logic [8:0] l, input logic [8:0] p);
    logic a, e;
    a = (l[7:0] == "(") || (l[7:0] == ";") || (l[7:0] == ",") || (l[7:0] == "{") ||
        (l[7:0] == "+") || (l[7:0] == "*") || (l[7:0] == "/") || (l[7:0] == "%") ||
        (l[7:0] == "<") || (l[7:0] == ">") || (l[7:0] == "!") || (l[7:0] == "&") ||
        (l[7:0] == "|");
    e = p[8] || (p[7:0] == "=") || (p[7:0] == "+") || (p[7:0] == "-") ||
        (p[7:0] == "*") || (p[7:0] == "/") || (p[7:0] == "%") || (p[7:0] == "(") ||
        (p[7:0] == "<") || (p[7:0] == ">") || (p[7:0] == "!") || (p[7:0] == "&") ||
        (p[7:0] == "|") || (p[7:0] == ";") || (p[7:0] == ",") || (p[7:0] == "{");
    sign_ok = l[8] || a || ((l[7:0] == "=") && e);
  endfunction

  // keyword match over the window
  always_comb begin
    logic [63:0] txt;
    logic        hit;
    id_kind = K_IDENT;
    for (int i = 7; i >= 0; i--) begin
      txt = kw_text(3'(i));
      hit = (rlen_r == 16'(kw_len(3'(i))));
      for (int j = 0; j < 8; j++) begin
        if (j < int'(kw_len(3'(i))) && win_r[j] != txt[63-8*j -: 8]) hit = 1'b0;
      end
      if (hit) id_kind = 6'(i);
    end
  end

  always_comb begin
    fl_have = 1'b1;
    fl_len  = 16'd1;
    case (mode_r)
      M_SLASH:  fl_kind = K_DIV;
      M_IDENT:  begin fl_kind = id_kind; fl_len = rlen_r; end
      M_NUMBER: begin fl_kind = K_INT; fl_len = rlen_r; end
      M_MINUS:  fl_kind = K_MINUS;
      M_OP2:    fl_kind = op2_kind(held_r, 1'b0);
      default:  begin fl_kind = K_UNKNOWN; fl_have = 1'b0; end
    endcase
  end

  always_comb begin
    b          = in_data.source_byte;
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    rlen_nxt   = rlen_r;
    lsc_nxt    = lsc_r;
    scb_nxt    = scb_r;
    lnb_nxt    = lnb_r;
    mis_nxt    = mis_r;
    win_we     = 1'b0;
    win_idx    = '0;
    restart    = 1'b0;
    fl_v       = 1'b0;
    em_v       = 1'b0;
    em_kind    = K_UNKNOWN;
    em_start   = pos_r;
    em_len     = 16'd1;
    if (acc && in_data.kind) begin
      fl_v       = fl_have;
      em_v       = 1'b1;
      em_kind    = K_EOF;
      em_len     = 16'd0;
      mode_nxt   = M_IDLE;
      held_nxt   = '0;
      pos_nxt    = '0;
      tstart_nxt = '0;
      rlen_nxt   = '0;
      lsc_nxt    = NONE_CHAR;
      scb_nxt    = NONE_CHAR;
      lnb_nxt    = NONE_CHAR;
      mis_nxt    = 1'b0;
    end else if (acc) begin
      case (mode_r)
        M_IDLE:  restart = 1'b1;
        M_SLASH: begin
          if (b == "/") mode_nxt = M_LINE;
          else if (b == "*") mode_nxt = M_BLOCK;
          else restart = 1'b1;
        end
        M_LINE:  if (b == 8'h0A) mode_nxt = M_IDLE;
        M_BLOCK: if (b == "*") mode_nxt = M_BSTAR;
        M_BSTAR: begin
          if (b == "/") mode_nxt = M_IDLE;
          else if (b != "*") mode_nxt = M_BLOCK;
        end
        M_IDENT: begin
          if (is_alp(b) || is_dig(b)) begin
            if (rlen_r < 16'(KEYWORD_CHARS)) begin
              win_we  = 1'b1;
              win_idx = rlen_r[KW_IDX_W-1:0];
            end
            if (rlen_r != 16'hFFFF) rlen_nxt = rlen_r + 16'd1;
          end else restart = 1'b1;
        end
        M_NUMBER: begin
          if (is_dig(b)) begin
            if (rlen_r != 16'hFFFF) rlen_nxt = rlen_r + 16'd1;
          end else restart = 1'b1;
        end
        M_MINUS: begin
          if (is_dig(b) && mis_r) begin
            rlen_nxt = 16'd2;
            if (b == "0") begin
              em_v     = 1'b1;
              em_kind  = K_INT;
              em_start = tstart_r;
              em_len   = 16'd2;
              mode_nxt = M_IDLE;
            end else mode_nxt = M_NUMBER;
          end else restart = 1'b1;
        end
        M_OP2: begin
          if (b == (((held_r == "&") || (held_r == "|")) ? held_r : 8'("="))) begin
            em_v     = 1'b1;
            em_kind  = op2_kind(held_r, 1'b1);
            em_start = tstart_r;
            em_len   = 16'd2;
            mode_nxt = M_IDLE;
          end else restart = 1'b1;
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        fl_v     = fl_have;
        mode_nxt = M_IDLE;
        if (!is_ws6(b)) begin
          tstart_nxt = pos_r;
          rlen_nxt   = 16'd1;
          if (b == "/") mode_nxt = M_SLASH;
          else if (b == "0") em_v = 1'b1;
          else if (is_dig(b)) mode_nxt = M_NUMBER;
          else if (b == "-") begin
            mis_nxt  = sign_ok(lsc_r, scb_r);
            mode_nxt = M_MINUS;
          end else if (is_alp(b)) begin
            win_we   = 1'b1;
            mode_nxt = M_IDENT;
          end else if (is_op2(b)) begin
            held_nxt = b;
            mode_nxt = M_OP2;
          end else em_v = 1'b1;
          em_kind = single_kind(b);
        end
      end
      if (!is_ws6(b)) begin
        scb_nxt = lnb_r;
        lsc_nxt = {1'b0, b};
        lnb_nxt = {1'b0, b};
      end else if (!is_ws4(b)) begin
        lnb_nxt = {1'b0, b};
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_comb begin
    // restart the token index once the end marker has taken its eof
    if (acc && in_data.kind) tcnt_nxt = '0;
    else tcnt_nxt = tcnt_r + 32'(fl_v) + 32'(em_v);
    t_fl.token_kind   = fl_kind;
    t_fl.token_number = tcnt_r;
    t_fl.start_offset = 32'(tstart_r);
    t_fl.token_length = fl_len;
    t_fl.last_of_run  = !em_v;
    t_em.token_kind   = em_kind;
    t_em.token_number = fl_v ? tcnt_r + 32'd1 : tcnt_r;
    t_em.start_offset = 32'(em_start);
    t_em.token_length = em_len;
    t_em.last_of_run  = 1'b1;
    push           = fl_v || em_v;
    push_data.two  = fl_v && em_v;
    push_data.tok0 = fl_v ? t_fl : t_em;
    push_data.tok1 = t_em;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      tcnt_r <= '0;
      lsc_r  <= NONE_CHAR;
      scb_r  <= NONE_CHAR;
      lnb_r  <= NONE_CHAR;
      mis_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tcnt_r <= tcnt_nxt;
      lsc_r  <= lsc_nxt;
      scb_r  <= scb_nxt;
      lnb_r  <= lnb_nxt;
      mis_r  <= mis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r   <= held_nxt;
    tstart_r <= tstart_nxt;
    rlen_r   <= rlen_nxt;
    if (win_we) win_r[win_idx] <= b;
  end

endmodule

// ===== hdl/cst_queue.sv =====
module cst_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cst_pkg::bundle_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output cst_pkg::bundle_t head
);
  import cst_pkg::*;

  bundle_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

endmodule

// ===== hdl/cst_back.sv =====
module cst_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             not_empty,
  input  cst_pkg::bundle_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output cst_pkg::out_t    out_data
);
  import cst_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic second_r, second_nxt;
  logic load;
  out_t out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    load          = not_empty && (!out_valid_r || !out_stall);
    out_valid_nxt = load || (out_valid_r && out_stall);
    second_nxt    = second_r;
    pop           = 1'b0;
    if (load) begin
      if (head.two && !second_r) second_nxt = 1'b1;
      else begin
        second_nxt = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= second_r ? head.tok1 : head.tok0;
  end

endmodule

// ===== hdl/c_subset_tokenizer.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_data (cst_pkg::in_t)
// out_    | output    | out_valid/out_stall| out_data (cst_pkg::out_t)
//
// One byte or end marker is taken every cycle while the token queue has room.
// A transaction yields zero, one or two tokens; the output register drains one
// token a cycle while out_stall is low; transactions are taken one a cycle while
// the queue has room. The four-entry queue sets the slack.
// Reset is synchronous, active low; it clears lexer state and empties the queue.
// in_stall rises only when the queue is full; out_stall holds the output register.
module c_subset_tokenizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cst_pkg::out_t out_data
);
  import cst_pkg::*;

  logic    acc, push, pop, full, not_empty;
  bundle_t push_data, head;

  // accept a transaction whenever the queue can take its tokens
  assign in_stall = full;
  assign acc      = in_valid && !full;

  // front: classify each byte and build the tokens it completes
  cst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  // queue: hold token bundles so either side may stall alone
  cst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // back: drain one token a cycle into the output register while out_stall is low
  cst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/cst_checker.sv =====
module cst_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input cst_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cst_pkg::out_t out_data
);
  import cst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_free_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == K_EOF |->
      out_data.token_length == 16'd0 && out_data.last_of_run)
    else $error("bad eof token");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.token_kind == K_EOF ##1 out_valid |->
      out_data.token_number == 32'd0)
    else $error("token index not restarted after eof");

endmodule

bind c_subset_tokenizer cst_checker u_cst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/c_subset_tokenizer_tb.sv =====
`timescale 1ns / 1ps

module c_subset_tokenizer_tb;
  import cst_pkg::*;

  localparam logic [8:0] NO_CHAR = NONE_CHAR;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  c_subset_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Lexer state of the predictor.
  mode_t       lx_mode;
  logic [7:0]  lx_held;
  logic [7:0]  lx_window [KEYWORD_CHARS];
  logic [31:0] lx_pos, lx_start, lx_count;
  logic [15:0] lx_len;
  logic [8:0]  lx_last, lx_prev, lx_last_nb;
  logic        lx_sign;

  out_t token_q[$];
  out_t item_toks[$];
  int   fail_count = 0;
  bit   idle_on = 1'b1;
  bit   hold_rx = 1'b0;

  function automatic bit ws4(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction
  function automatic bit ws6(logic [7:0] c);
    return ws4(c) || c == 8'h0b || c == 8'h0c;
  endfunction
  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  task automatic lx_reset();
    lx_mode = M_IDLE; lx_held = '0;
    foreach (lx_window[i]) lx_window[i] = '0;
    lx_pos = '0; lx_start = '0; lx_len = '0; lx_count = '0;
    lx_last = NO_CHAR; lx_prev = NO_CHAR; lx_last_nb = NO_CHAR; lx_sign = 1'b0;
  endtask

  task automatic push_token(logic [5:0] k, logic [31:0] st, logic [15:0] ln);
    out_t t;
    t.token_kind = k; t.token_number = lx_count; t.start_offset = st;
    t.token_length = ln; t.last_of_run = 1'b0;
    item_toks.insert(item_toks.size(), t);
    lx_count++;
  endtask

  function automatic bit sign_ok();
    if (lx_last == NO_CHAR) return 1;
    if (lx_last[8]) return 0;
    case (lx_last[7:0])
      "(", ";", ",", "{", "+", "*", "/", "%", "<", ">", "!", "&", "|": return 1;
      "=": begin
        if (lx_prev == NO_CHAR) return 1;
        case (lx_prev[7:0])
          "=", "+", "-", "*", "/", "%", "(", "<", ">", "!", "&", "|", ";", ",", "{":
            return 1;
          default: return 0;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    logic [63:0] w;
    if (lx_len > KEYWORD_CHARS) return K_IDENT;
    for (int k = 0; k < 8; k++) begin
      w = '0;
      for (int j = 0; j < 8; j++)
        if (j < lx_len) w[63-8*j -: 8] = lx_window[j];
      if (lx_len == kw_len(k[2:0]) && w == kw_text(k[2:0])) return k[5:0];
    end
    return K_IDENT;
  endfunction

  function automatic logic [5:0] pair_kind(logic [7:0] h, bit paired);
    case (h)
      "=": return paired ? K_EQ : K_ASSIGN;
      "!": return paired ? K_NE : K_NOT;
      "<": return paired ? K_LE : K_LT;
      ">": return paired ? K_GE : K_GT;
      "&": return paired ? K_ANDAND : K_UNKNOWN;
      default: return paired ? K_OROR : K_UNKNOWN;
    endcase
  endfunction

  task automatic flush_token();
    case (lx_mode)
      M_SLASH:  push_token(K_DIV, lx_start, 16'd1);
      M_IDENT:  push_token(word_kind(), lx_start, lx_len);
      M_NUMBER: push_token(K_INT, lx_start, lx_len);
      M_MINUS:  push_token(K_MINUS, lx_start, 16'd1);
      M_OP2:    push_token(pair_kind(lx_held, 0), lx_start, 16'd1);
      default: ;
    endcase
    lx_mode = M_IDLE;
  endtask

  task automatic open_token(logic [7:0] b);
    lx_mode = M_IDLE;
    if (!ws6(b)) begin
      lx_start = lx_pos; lx_len = 16'd1;
      if (b == "/") lx_mode = M_SLASH;
      else if (b == "0") push_token(K_INT, lx_pos, 16'd1);
      else if (digit(b)) lx_mode = M_NUMBER;
      else if (b == "-") begin
        lx_sign = sign_ok(); lx_mode = M_MINUS;
      end else if (alpha(b)) begin
        lx_window[0] = b; lx_mode = M_IDENT;
      end else if (b inside {"=", "!", "<", ">", "&", "|"}) begin
        lx_held = b; lx_mode = M_OP2;
      end else begin
        case (b)
          "+": push_token(K_PLUS, lx_pos, 16'd1);
          "*": push_token(K_STAR, lx_pos, 16'd1);
          "%": push_token(K_MOD, lx_pos, 16'd1);
          "(": push_token(K_LPAREN, lx_pos, 16'd1);
          ")": push_token(K_RPAREN, lx_pos, 16'd1);
          "{": push_token(K_LBRACE, lx_pos, 16'd1);
          "}": push_token(K_RBRACE, lx_pos, 16'd1);
          ";": push_token(K_SEMI, lx_pos, 16'd1);
          ",": push_token(K_COMMA, lx_pos, 16'd1);
          default: push_token(K_UNKNOWN, lx_pos, 16'd1);
        endcase
      end
    end
  endtask

  // Work out the tokens one transaction yields and queue them for checking.
  task automatic predict_tokens(in_t it);
    logic [7:0] b;
    out_t t;
    b = it.source_byte;
    item_toks.delete();
    if (it.kind) begin
      flush_token();
      push_token(K_EOF, lx_pos, 16'd0);
      lx_reset();
    end else begin
      case (lx_mode)
        M_IDLE: open_token(b);
        M_SLASH:
          if (b == "/") lx_mode = M_LINE;
          else if (b == "*") lx_mode = M_BLOCK;
          else begin flush_token(); open_token(b); end
        M_LINE:  if (b == 8'h0a) lx_mode = M_IDLE;
        M_BLOCK: if (b == "*") lx_mode = M_BSTAR;
        M_BSTAR:
          if (b == "/") lx_mode = M_IDLE;
          else if (b != "*") lx_mode = M_BLOCK;
        M_IDENT:
          if (alpha(b) || digit(b)) begin
            if (lx_len < KEYWORD_CHARS) lx_window[lx_len] = b;
            if (lx_len != 16'hffff) lx_len++;
          end else begin flush_token(); open_token(b); end
        M_NUMBER:
          if (digit(b)) begin
            if (lx_len != 16'hffff) lx_len++;
          end else begin flush_token(); open_token(b); end
        M_MINUS:
          if (digit(b) && lx_sign) begin
            lx_len = 16'd2;
            if (b == "0") begin
              push_token(K_INT, lx_start, 16'd2); lx_mode = M_IDLE;
            end else lx_mode = M_NUMBER;
          end else begin flush_token(); open_token(b); end
        M_OP2:
          if (b == ((lx_held == "&" || lx_held == "|") ? lx_held : 8'h3d)) begin
            push_token(pair_kind(lx_held, 1), lx_start, 16'd2); lx_mode = M_IDLE;
          end else begin flush_token(); open_token(b); end
        default: begin lx_mode = M_IDLE; open_token(b); end
      endcase
      if (!ws6(b)) begin
        lx_prev = lx_last_nb; lx_last = {1'b0, b}; lx_last_nb = {1'b0, b};
      end else if (!ws4(b)) lx_last_nb = {1'b0, b};
      lx_pos++;
    end
    if (item_toks.size() > 0) item_toks[$].last_of_run = 1'b1;
    while (item_toks.size() > 0) begin
      t = item_toks.pop_front();
      token_q.insert(token_q.size(), t);
    end
  endtask

  // Offer one transaction; hold the payload until it is taken.
  task automatic send_item(bit eoi, logic [7:0] b);
    in_t it;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    it.kind = eoi; it.source_byte = b;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(it);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (token_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver: random stall bursts unless a long hold is in force.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_rx) out_stall <= 1'b1;
      else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n - 1) begin
          @(negedge clk);
          if (!hold_rx && !idle_on) break;
        end
        out_stall <= hold_rx;
      end else out_stall <= 1'b0;
    end
  end

  // Compare every accepted token with the oldest prediction.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("unexpected token kind=%0d", out_data.token_kind);
        fail_count++;
      end else begin
        e = token_q.pop_front();
        if (out_data.token_kind !== e.token_kind) begin
          $error("token_kind exp %0d got %0d", e.token_kind, out_data.token_kind);
          fail_count++;
        end
        if (out_data.token_number !== e.token_number) begin
          $error("token_number exp %0d got %0d", e.token_number, out_data.token_number);
          fail_count++;
        end
        if (out_data.start_offset !== e.start_offset) begin
          $error("start_offset exp %0d got %0d", e.start_offset, out_data.start_offset);
          fail_count++;
        end
        if (out_data.token_length !== e.token_length) begin
          $error("token_length exp %0d got %0d", e.token_length, out_data.token_length);
          fail_count++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, out_data.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Directed: keywords, most operators, sign rule, comments, odd bytes.
  task automatic test_directed();
    send_text("int x=-5;while(a!=-0)");
    send_item(1'b1, 8'h00);
    send_text("b-1 c=/*/ */=-2 //z\n&|&&||");
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
    send_text("void if else break continue return continues<=>=<>!%*+,{}\v-3\f-");
    send_item(1'b1, 8'h00);
  endtask

  // Fill the block while the receiver holds off, then wait for a full drain.
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (60) @(negedge clk);
        hold_rx = 1'b0;
      end
      send_text("a+b;c*d,(e)");
    join
    wait_drained();
  endtask

  function automatic logic [7:0] pick_char();
    string alphabet = "intvoidfelswhbrkcu_Zx09123456789+-*/%=!<>&|(){};, \t\n\r";
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 255);
      default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endfunction

  // Random: mostly snippets of well-formed text, some raw noise.
  task automatic test_random(int n_items);
    string snips[] = '{"int ", "return ", "continue;", "x1=-7;", "a==-3", "if(b<=-1)",
                        "/*c*/", "//l\n", "y-2", "{z=0;}", "while(q&&r||s)", "s!=t",
                        "averyverylongname ", "0012", "=-4", "-9"};
    string snip;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        snip = snips[$urandom_range(0, snips.size() - 1)];
        send_text(snip);
        sent += snip.len();
      end else begin
        send_item(1'b0, pick_char());
        sent++;
      end
      if ($urandom_range(0, 40) == 0) send_item(1'b1, $urandom_range(0, 255));
    end
    send_item(1'b1, 8'h00);
  endtask

  initial begin
    lx_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(180);
    idle_on = 1'b0;
    test_random(50);
    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && token_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
